// File: rtl/core/nghe_pkg.sv
// Package for the noise gate: field widths, configuration indexes and reset values.
`default_nettype none

package nghe_pkg;

  localparam int unsigned SampleW   = 16;
  localparam int unsigned LevelW    = 16;
  localparam int unsigned PeakW     = 17;
  localparam int unsigned GainW     = 17;
  localparam int unsigned StepW     = 17;
  localparam int unsigned HoldW     = 21;
  localparam int unsigned HoldCfgW  = 20;
  localparam int unsigned CfgIndexW = 8;
  localparam int unsigned CfgDataW  = 20;

  localparam logic [GainW-1:0] GainUnity = GainW'(65536);
  localparam logic [HoldW-1:0] HoldMax   = '1;

  // Configuration register indexes
  typedef enum logic [CfgIndexW-1:0] {
    CFG_GATE_ENABLE     = 8'd0,
    CFG_OUTPUT_BYPASS   = 8'd1,
    CFG_OPEN_THRESHOLD  = 8'd2,
    CFG_CLOSE_THRESHOLD = 8'd3,
    CFG_ATTACK_STEP     = 8'd4,
    CFG_RELEASE_STEP    = 8'd5,
    CFG_HOLD_FRAMES     = 8'd6,
    CFG_PEAK_DECAY_STEP = 8'd7
  } cfg_index_t;

  // Reset values of the configuration registers
  localparam logic [15:0]         OpenThresholdRst  = 16'd1653;
  localparam logic [15:0]         CloseThresholdRst = 16'd824;
  localparam logic [StepW-1:0]    AttackStepRst     = 17'd59;
  localparam logic [StepW-1:0]    ReleaseStepRst    = 17'd10;
  localparam logic [HoldCfgW-1:0] HoldFramesRst     = 20'd8820;
  localparam logic [15:0]         PeakDecayStepRst  = 16'd1;

endpackage

`default_nettype wire

// File: rtl/core/noise_gate_hysteresis_envelope_top.sv
// Stereo noise gate with hysteresis, decaying peak detector and attack/hold/release gain.
//
// Usage:
//   s_* carries one stereo frame per transaction, s_tdata = {in_right, in_left}.
//   m_* returns one scaled frame per input frame in the same order,
//   m_tdata = {out_right, out_left}, m_tuser = gate_open after that frame.
//   cfg_* writes one configuration register per transaction (cfg_index, cfg_data);
//   cfg_ready is always high. Write configuration only while the block is idle.
// The frame passes through the input, multiply-stage and output registers on its way to m_*.
// Throughput: one frame per cycle while m_* is not stalled. The gate, peak, hold and gain state
//   is updated by the second stage, and the gain multiply runs in the third.
// Reset (rst, synchronous): pipeline empty, gate disabled, gate state cleared,
//   configuration registers at their reset values.
// Stall: while m_tvalid is high and m_tready low the whole pipeline holds and
//   s_tready drops; no frame is lost or repeated.
`default_nettype none

module noise_gate_hysteresis_envelope_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // slave stream
  input  wire logic                               s_tvalid,
  output      logic                               s_tready,
  input  wire logic [2*nghe_pkg::SampleW-1:0]     s_tdata,   // [15:0] in_left, [31:16] in_right
  // master stream
  output      logic                               m_tvalid,
  input  wire logic                               m_tready,
  output      logic [2*nghe_pkg::SampleW-1:0]     m_tdata,   // [15:0] out_left, [31:16] out_right
  output      logic                               m_tuser,   // [0] gate_open
  // configuration write channel
  input  wire logic                               cfg_valid,
  output      logic                               cfg_ready,
  input  wire logic [nghe_pkg::CfgIndexW-1:0]     cfg_index,
  input  wire logic [nghe_pkg::CfgDataW-1:0]      cfg_data
);

  import nghe_pkg::*;

  // configuration registers
  logic                gate_enable;
  logic                output_bypass;
  logic [15:0]         open_threshold;
  logic [15:0]         close_threshold;
  logic [StepW-1:0]    attack_step;
  logic [StepW-1:0]    release_step;
  logic [HoldCfgW-1:0] hold_frames;
  logic [15:0]         peak_decay_step;

  // gate state
  logic                    gate_is_open;
  logic signed [PeakW-1:0] peak_level;
  logic [GainW-1:0]        gain;
  logic [HoldW-1:0]        hold_count;

  // pipeline registers
  logic                      in_valid;
  logic signed [SampleW-1:0] in_left;
  logic signed [SampleW-1:0] in_right;
  logic                      mul_valid;
  logic signed [SampleW-1:0] mul_left;
  logic signed [SampleW-1:0] mul_right;
  logic [GainW-1:0]          mul_gain;
  logic                      mul_pass;
  logic                      mul_open;

  logic advance;

  // Whole pipeline moves when the output register is free or being drained
  assign advance   = !m_tvalid || m_tready;
  assign s_tready  = advance;
  assign cfg_ready = 1'b1;

  // Write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      gate_enable     <= 1'b0;
      output_bypass   <= 1'b0;
      open_threshold  <= OpenThresholdRst;
      close_threshold <= CloseThresholdRst;
      attack_step     <= AttackStepRst;
      release_step    <= ReleaseStepRst;
      hold_frames     <= HoldFramesRst;
      peak_decay_step <= PeakDecayStepRst;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_GATE_ENABLE:     gate_enable     <= cfg_data[0];
        CFG_OUTPUT_BYPASS:   output_bypass   <= cfg_data[0];
        CFG_OPEN_THRESHOLD:  open_threshold  <= cfg_data[15:0];
        CFG_CLOSE_THRESHOLD: close_threshold <= cfg_data[15:0];
        CFG_ATTACK_STEP:     attack_step     <= cfg_data[StepW-1:0];
        CFG_RELEASE_STEP:    release_step    <= cfg_data[StepW-1:0];
        CFG_HOLD_FRAMES:     hold_frames     <= cfg_data[HoldCfgW-1:0];
        CFG_PEAK_DECAY_STEP: peak_decay_step <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Capture the input frame
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (advance) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      in_left  <= s_tdata[SampleW-1:0];
      in_right <= s_tdata[2*SampleW-1:SampleW];
    end
  end

  // Level and state update for the registered frame
  logic signed [SampleW:0]   frame_sum;
  logic [SampleW+1:0]        frame_abs;
  logic [LevelW-1:0]         level;
  logic signed [PeakW-1:0]   level_ext;
  logic signed [PeakW-1:0]   peak_top;
  logic signed [PeakW:0]     peak_diff;
  logic                      opened;
  logic                      close_hit;
  logic                      gate_open_next;
  logic signed [PeakW-1:0]   peak_level_next;
  logic [GainW-1:0]          gain_next;
  logic [HoldW-1:0]          hold_count_next;
  logic [GainW:0]            gain_up;
  logic [HoldW-1:0]          hold_base;

  always_comb begin
    frame_sum = {in_left[SampleW-1], in_left} + {in_right[SampleW-1], in_right};
    frame_abs = frame_sum[SampleW] ? (SampleW+2)'(-$signed({frame_sum[SampleW], frame_sum}))
                                   : (SampleW+2)'($signed({frame_sum[SampleW], frame_sum}));
    level     = frame_abs[LevelW:1];
    level_ext = $signed({1'b0, level});

    opened    = gate_is_open || (level > open_threshold);
    close_hit = $signed({peak_level[PeakW-1], peak_level}) < $signed({2'b00, close_threshold});
    gate_open_next = opened && !close_hit;

    // Decaying peak
    peak_top        = (peak_level > level_ext) ? peak_level : level_ext;
    peak_diff       = $signed({peak_top[PeakW-1], peak_top}) - $signed({2'b00, peak_decay_step});
    peak_level_next = peak_diff[PeakW-1:0];

    // Attack, hold and release
    gain_up         = {1'b0, gain} + {1'b0, attack_step};
    hold_base       = (opened && close_hit) ? '0 : hold_count;
    hold_count_next = hold_count;
    gain_next       = gain;
    if (gate_open_next) begin
      gain_next = (gain_up > {1'b0, GainUnity}) ? GainUnity : gain_up[GainW-1:0];
    end else begin
      hold_count_next = (hold_base == HoldMax) ? hold_base : hold_base + HoldW'(1);
      if (hold_count_next > {1'b0, hold_frames}) begin
        gain_next = (gain > release_step) ? gain - release_step : '0;
      end
    end
  end

  // Advance the gate state once per frame; clear it while disabled
  always_ff @(posedge clk) begin
    if (rst) begin
      gate_is_open <= 1'b0;
      peak_level   <= '0;
      gain         <= '0;
      hold_count   <= '0;
    end else if (advance && in_valid) begin
      if (!gate_enable) begin
        gate_is_open <= 1'b0;
        peak_level   <= '0;
        gain         <= '0;
        hold_count   <= '0;
      end else begin
        gate_is_open <= gate_open_next;
        peak_level   <= peak_level_next;
        gain         <= gain_next;
        hold_count   <= hold_count_next;
      end
    end
  end

  // Hand the frame and its gain to the multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (advance) begin
      mul_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mul_left  <= in_left;
      mul_right <= in_right;
      mul_gain  <= gain_next;
      mul_pass  <= !gate_enable || output_bypass;
      mul_open  <= gate_enable && gate_open_next;
    end
  end

  // Scale by the gain, floor of the Q16 product
  logic signed [GainW:0]          gain_s;
  logic signed [SampleW+GainW:0]  prod_left;
  logic signed [SampleW+GainW:0]  prod_right;
  logic [SampleW-1:0]             res_left;
  logic [SampleW-1:0]             res_right;

  always_comb begin
    gain_s     = $signed({1'b0, mul_gain});
    prod_left  = (SampleW+GainW+1)'(mul_left) * (SampleW+GainW+1)'(gain_s);
    prod_right = (SampleW+GainW+1)'(mul_right) * (SampleW+GainW+1)'(gain_s);
    res_left   = mul_pass ? mul_left  : prod_left[SampleW+15:16];
    res_right  = mul_pass ? mul_right : prod_right[SampleW+15:16];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {res_right, res_left};
      m_tuser <= mul_open;
    end
  end

endmodule

`default_nettype wire

// File: dv/noise_gate_hysteresis_envelope_checker.sv
// Checker for the noise gate: mirrors configuration, predicts each gated frame and compares.
`default_nettype none

module noise_gate_hysteresis_envelope_checker
  import nghe_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_tvalid,
  input  wire logic                     s_tready,
  input  wire logic [2*SampleW-1:0]     s_tdata,   // [15:0] in_left, [31:16] in_right
  input  wire logic                     m_tvalid,
  input  wire logic                     m_tready,
  input  wire logic [2*SampleW-1:0]     m_tdata,   // [15:0] out_left, [31:16] out_right
  input  wire logic                     m_tuser,   // [0] gate_open
  input  wire logic                     cfg_valid,
  input  wire logic                     cfg_ready,
  input  wire logic [CfgIndexW-1:0]     cfg_index,
  input  wire logic [CfgDataW-1:0]      cfg_data,
  output int                            mismatches,
  output int                            outstanding
);

  typedef struct {
    logic [SampleW-1:0] left;
    logic [SampleW-1:0] right;
    logic               open;
  } gated_frame_t;

  // Mirror of the configuration registers
  logic                gate_en;
  logic                out_byp;
  logic [15:0]         open_thr;
  logic [15:0]         close_thr;
  logic [StepW-1:0]    atk_step;
  logic [StepW-1:0]    rel_step;
  logic [HoldCfgW-1:0] hold_len;
  logic [15:0]         decay_step;

  // Mirror of the envelope state
  logic                is_open;
  int                  peak;
  int                  gain_q;
  logic [HoldW-1:0]    hold_cnt;

  gated_frame_t        pending_frames[$];

  // Scale a sample by a Q1.16 gain, rounding toward minus infinity
  function automatic logic [SampleW-1:0] apply_gain(logic signed [SampleW-1:0] s, int g);
    longint prod;
    prod = longint'(s) * longint'(g);
    return SampleW'(prod >>> 16);
  endfunction

  function automatic void clear_envelope();
    is_open  = 1'b0;
    peak     = 0;
    gain_q   = 0;
    hold_cnt = '0;
  endfunction

  // Advance the envelope by one stereo frame and return the gated frame
  function automatic gated_frame_t gate_frame(logic signed [SampleW-1:0] l,
                                              logic signed [SampleW-1:0] r);
    gated_frame_t f;
    int           sum;
    int           lvl;
    int           top;
    sum = int'(l) + int'(r);
    lvl = (sum < 0 ? -sum : sum) >>> 1;
    f.left  = l;
    f.right = r;
    f.open  = 1'b0;
    if (!gate_en) begin
      clear_envelope();
      return f;
    end
    // hysteresis: open on level, close on the peak from before this frame
    if (!is_open && lvl > int'(open_thr)) is_open = 1'b1;
    if (is_open && peak < int'(close_thr)) begin
      hold_cnt = '0;
      is_open  = 1'b0;
    end
    top  = (peak > lvl) ? peak : lvl;
    peak = top - int'(decay_step);
    if (is_open) begin
      gain_q = gain_q + int'(atk_step);
      if (gain_q > int'(GainUnity)) gain_q = int'(GainUnity);
    end else begin
      if (hold_cnt < HoldMax) hold_cnt = hold_cnt + HoldW'(1);
      if (hold_cnt > {1'b0, hold_len})
        gain_q = (gain_q > int'(rel_step)) ? gain_q - int'(rel_step) : 0;
    end
    if (!out_byp) begin
      f.left  = apply_gain(l, gain_q);
      f.right = apply_gain(r, gain_q);
    end
    f.open = is_open;
    return f;
  endfunction

  task automatic compare_field(input string name, input logic [SampleW-1:0] want,
                               input logic [SampleW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Track configuration writes, compare results and queue predictions
  always @(posedge clk) begin
    gated_frame_t want;
    if (rst) begin
      gate_en    = 1'b0;
      out_byp    = 1'b0;
      open_thr   = OpenThresholdRst;
      close_thr  = CloseThresholdRst;
      atk_step   = AttackStepRst;
      rel_step   = ReleaseStepRst;
      hold_len   = HoldFramesRst;
      decay_step = PeakDecayStepRst;
      clear_envelope();
      pending_frames.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_GATE_ENABLE:     gate_en    = cfg_data[0];
          CFG_OUTPUT_BYPASS:   out_byp    = cfg_data[0];
          CFG_OPEN_THRESHOLD:  open_thr   = cfg_data[15:0];
          CFG_CLOSE_THRESHOLD: close_thr  = cfg_data[15:0];
          CFG_ATTACK_STEP:     atk_step   = cfg_data[StepW-1:0];
          CFG_RELEASE_STEP:    rel_step   = cfg_data[StepW-1:0];
          CFG_HOLD_FRAMES:     hold_len   = cfg_data[HoldCfgW-1:0];
          CFG_PEAK_DECAY_STEP: decay_step = cfg_data[15:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (pending_frames.size() == 0) begin
          $display("%0t: unexpected output transaction, expected none, actual %h gate %b",
                   $time, m_tdata, m_tuser);
          mismatches++;
        end else begin
          want = pending_frames.pop_front();
          compare_field("out_left", want.left, m_tdata[SampleW-1:0]);
          compare_field("out_right", want.right, m_tdata[2*SampleW-1:SampleW]);
          compare_field("gate_open", SampleW'(want.open), SampleW'(m_tuser));
        end
      end
      if (s_tvalid && s_tready)
        pending_frames.push_back(gate_frame(s_tdata[SampleW-1:0],
                                            s_tdata[2*SampleW-1:SampleW]));
    end
    outstanding = pending_frames.size();
  end

endmodule

`default_nettype wire

// File: dv/noise_gate_hysteresis_envelope_top_test.sv
// Testbench top for the noise gate: clock, reset, stimulus, back-pressure and verdict.
`default_nettype none

module noise_gate_hysteresis_envelope_top_test;
  import nghe_pkg::*;

  localparam int IdleLimit   = 4000;
  localparam int LongHoldOff = 400;
  localparam int RandPhases  = 10;
  localparam int PhaseFrames = 183;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [2*SampleW-1:0]   s_tdata   = '0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [2*SampleW-1:0]   m_tdata;
  logic                   m_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CfgIndexW-1:0]   cfg_index = '0;
  logic [CfgDataW-1:0]    cfg_data  = '0;

  int                     mismatches;
  int                     outstanding;

  // Pacing controls for the frame source and the result sink
  logic                   src_free      = 1'b0;
  logic                   sink_free     = 1'b0;
  int                     hold_off_req  = 0;
  int                     hold_off_seen = 0;
  int                     sink_wait     = 0;

  noise_gate_hysteresis_envelope_top u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  noise_gate_hysteresis_envelope_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly no gap, some short ones, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_step();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 65536;
      2:       return 1;
      default: return $urandom_range(1, 20000);
    endcase
  endfunction

  function automatic int pick_hold();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 1048575;
      default: return $urandom_range(0, 30);
    endcase
  endfunction

  // Result sink: random stalls, with an occasional long hold-off on request
  always @(posedge clk) begin
    if (hold_off_seen != hold_off_req) begin
      hold_off_seen <= hold_off_req;
      m_tready      <= 1'b0;
      sink_wait     <= LongHoldOff;
    end else if (sink_wait != 0) begin
      m_tready  <= 1'b0;
      sink_wait <= sink_wait - 1;
    end else if (sink_free || $urandom_range(0, 3) != 0) begin
      m_tready <= 1'b1;
    end else begin
      m_tready  <= 1'b0;
      sink_wait <= pick_gap();
    end
  end

  // Offer one stereo frame and hold it until the transaction completes
  task automatic send_frame(input logic [SampleW-1:0] l, input logic [SampleW-1:0] r);
    int gap;
    gap = src_free ? 0 : pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {r, l};
    do @(posedge clk); while (!s_tready);
  endtask

  // Stop offering and wait for every predicted frame to come back
  task automatic drain_frames();
    s_tvalid <= 1'b0;
    // let the checker count the last accepted frame before looking
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CfgDataW'(value);
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_gate(input int unsigned en, input int unsigned byp,
                              input int unsigned open_lvl, input int unsigned close_lvl,
                              input int unsigned atk, input int unsigned rel,
                              input int unsigned hold, input int unsigned decay);
    write_reg(CFG_GATE_ENABLE, en);
    write_reg(CFG_OUTPUT_BYPASS, byp);
    write_reg(CFG_OPEN_THRESHOLD, open_lvl);
    write_reg(CFG_CLOSE_THRESHOLD, close_lvl);
    write_reg(CFG_ATTACK_STEP, atk);
    write_reg(CFG_RELEASE_STEP, rel);
    write_reg(CFG_HOLD_FRAMES, hold);
    write_reg(CFG_PEAK_DECAY_STEP, decay);
    cfg_valid <= 1'b0;
  endtask

  // Watchdog: end the run when no transaction moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("noise_gate_hysteresis_envelope_top_test: FAIL");
    $finish;
  end

  initial begin : stimulus
    int          open_lvl;
    int          close_lvl;
    int          amp;
    int          kind;
    int          seg_len;
    int          sent;
    logic        neg;
    logic [15:0] mag_l;
    logic [15:0] mag_r;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Disabled after reset: frames pass through untouched, gate reads closed
    send_frame(16'sd0, 16'sd0);
    send_frame(16'sd32767, 16'sd32767);
    send_frame(-16'sd32768, -16'sd32768);
    send_frame(-16'sd32768, 16'sd32767);
    send_frame(16'sd1, -16'sd1);
    drain_frames();

    // Open, attack to unity, close on the old peak, hold, then release to zero
    program_gate(1, 0, 100, 50, 40000, 25000, 1, 16384);
    send_frame(16'sd32767, 16'sd32767);
    send_frame(16'sd32767, 16'sd32767);
    send_frame(-16'sd32768, -16'sd32768);
    send_frame(16'sd0, 16'sd0);
    send_frame(-16'sd1, 16'sd0);
    send_frame(-16'sd3, 16'sd5);
    send_frame(16'sd32767, -16'sd32768);
    send_frame(16'sd1, 16'sd1);
    send_frame(16'sd2000, 16'sd2000);
    drain_frames();

    // Bypass with zero thresholds, zero steps and no peak decay
    program_gate(1, 1, 0, 0, 0, 0, 0, 0);
    send_frame(16'sd1, 16'sd1);
    send_frame(-16'sd32768, 16'sd32767);
    send_frame(16'sd0, 16'sd0);
    send_frame(16'sd32767, 16'sd32767);
    drain_frames();

    // Top thresholds, full steps, longest hold and a huge peak decay
    program_gate(1, 0, 32768, 32768, 65536, 65536, 1048575, 65535);
    send_frame(-16'sd32768, -16'sd32768);
    send_frame(16'sd0, 16'sd0);
    send_frame(16'sd100, -16'sd100);
    drain_frames();

    // Random phases: bursts of loud, quiet and middling frames with random content
    for (int ph = 0; ph < RandPhases; ph++) begin
      case ($urandom_range(0, 3))
        0:       open_lvl = $urandom_range(0, 200);
        1, 2:    open_lvl = $urandom_range(200, 4000);
        default: open_lvl = $urandom_range(4000, 32768);
      endcase
      close_lvl = $urandom_range(0, open_lvl);
      program_gate(($urandom_range(0, 7) != 0), ($urandom_range(0, 5) == 0),
                   open_lvl, close_lvl, pick_step(), pick_step(), pick_hold(),
                   ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(0, 300));
      src_free  = (ph == 2) || ($urandom_range(0, 3) == 0);
      sink_free = ($urandom_range(0, 3) == 0);
      // fill the pipeline against a long sink hold-off
      if (ph == 2) hold_off_req++;
      sent = 0;
      while (sent < PhaseFrames) begin
        // pause the source until every frame has come back
        if ($urandom_range(0, 39) == 0) drain_frames();
        kind    = $urandom_range(0, 9);
        seg_len = $urandom_range(1, 40);
        if (kind < 4)      amp = (open_lvl < 32767) ? $urandom_range(open_lvl + 1, 32767) : 32767;
        else if (kind < 7) amp = $urandom_range(0, close_lvl > 32767 ? 32767 : close_lvl);
        else               amp = $urandom_range(close_lvl > 32767 ? 32767 : close_lvl,
                                                open_lvl > 32767 ? 32767 : open_lvl);
        neg = $urandom_range(0, 1);
        for (int k = 0; k < seg_len && sent < PhaseFrames; k++) begin
          if (kind == 9) begin
            send_frame(16'($urandom), 16'($urandom));
          end else begin
            mag_l = 16'($urandom_range(amp - amp / 8, amp));
            mag_r = 16'($urandom_range(amp - amp / 8, amp));
            // negative side uses the one's complement so -32768 is reachable
            send_frame(neg ? ~mag_l : mag_l, neg ? ~mag_r : mag_r);
          end
          sent++;
        end
      end
      drain_frames();
    end

    sink_free = 1'b1;
    drain_frames();
    repeat (6) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("noise_gate_hysteresis_envelope_top_test: PASS");
    else
      $display("noise_gate_hysteresis_envelope_top_test: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
rtl/core/nghe_pkg.sv
rtl/core/noise_gate_hysteresis_envelope_top.sv
dv/noise_gate_hysteresis_envelope_checker.sv
dv/noise_gate_hysteresis_envelope_top_test.sv
